// ===== rtl/core/loudest_channel_selector_assert.svh =====
// ----------------------------------------------------------------------------
// Loudest channel selector assertion macros
// Shared property forms for the checker, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef LOUDEST_CHANNEL_SELECTOR_ASSERT_SVH
`define LOUDEST_CHANNEL_SELECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Loudest channel selector package
// Shared widths, register indices and types of the selector.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int SUM_W     = 34;
	localparam int CH_SLOTS  = 8;
	localparam int CH_W      = 3;
	localparam int OUT_W     = 24;
	localparam int AM_W      = 4;
	localparam int FPB_W     = 11;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_MICS      = 1'b0,
		CFG_FRAMES_PER_BLOCK = 1'b1
	} cfg_reg_t;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [CH_W-1:0]  ch_t;
	typedef logic [AM_W-1:0]  mics_t;

	// Control from the frame pipeline to the energy accumulators.
	typedef struct packed {
		logic move;
		logic last;
	} acc_ctl_t;

endpackage

// ===== rtl/core/lcs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/lcs_energy.sv =====
// ----------------------------------------------------------------------------
// Channel energy accumulators
// Adds each active channel's sample magnitude into a saturating sum and hands
// the block totals on at the last frame of a block.
// ----------------------------------------------------------------------------
module lcs_energy #(
	parameter int MAX_MICS    = 8,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lcs_pkg::acc_ctl_t                      ctl,
	input  lcs_pkg::mics_t                         mics,
	input  logic [MAX_MICS-1:0][SAMPLE_BITS-1:0]   samples,
	output lcs_pkg::sum_t [MAX_MICS-1:0]           final_sums,
	output logic                                   final_valid
);

	import lcs_pkg::*;

	sum_t [MAX_MICS-1:0] energy_q;
	sum_t [MAX_MICS-1:0] final_q;
	logic                final_v_q;
	sum_t [MAX_MICS-1:0] acc;
	logic [MAX_MICS-1:0] act;

	always_comb begin
		logic [SAMPLE_BITS-1:0] mag;
		logic [SUM_W:0]         s;
		for (int c = 0; c < MAX_MICS; c++) begin
			mag = samples[c][SAMPLE_BITS-1] ? (~samples[c] + 1'b1) : samples[c];
			s = {1'b0, energy_q[c]} + (SUM_W+1)'(mag);
			acc[c] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
			act[c] = AM_W'(c) < mics;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q  <= '0;
			final_v_q <= 1'b0;
		end else begin
			final_v_q <= ctl.move && ctl.last;
			if (ctl.move) begin
				for (int c = 0; c < MAX_MICS; c++) begin
					if (ctl.last) begin
						energy_q[c] <= '0;
					end else if (act[c]) begin
						energy_q[c] <= acc[c];
					end
				end
			end
		end
	end

	// Inactive channels are zeroed here so they can never win the selection.
	always_ff @(posedge clk) begin
		if (ctl.move && ctl.last) begin
			for (int c = 0; c < MAX_MICS; c++) begin
				final_q[c] <= act[c] ? acc[c] : '0;
			end
		end
	end

	assign final_sums  = final_q;
	assign final_valid = final_v_q;

endmodule

// ===== rtl/core/lcs_pick.sv =====
// ----------------------------------------------------------------------------
// Loudest channel pick
// Three-level compare tree over the block totals; the lower index wins ties.
// ----------------------------------------------------------------------------
module lcs_pick #(
	parameter int MAX_MICS = 8
) (
	input  lcs_pkg::sum_t [MAX_MICS-1:0] sums,
	output lcs_pkg::ch_t                 best,
	output logic                         found
);

	import lcs_pkg::*;

	sum_t [CH_SLOTS-1:0] lv0;
	sum_t [3:0]          lv1;
	ch_t  [3:0]          id1;
	sum_t [1:0]          lv2;
	ch_t  [1:0]          id2;

	for (genvar i = 0; i < CH_SLOTS; i++) begin : g_pad
		if (i < MAX_MICS) begin : g_used
			assign lv0[i] = sums[i];
		end else begin : g_zero
			assign lv0[i] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (lv0[2*i] >= lv0[2*i+1]) begin
				lv1[i] = lv0[2*i];
				id1[i] = CH_W'(2*i);
			end else begin
				lv1[i] = lv0[2*i+1];
				id1[i] = CH_W'(2*i+1);
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (lv1[2*i] >= lv1[2*i+1]) begin
				lv2[i] = lv1[2*i];
				id2[i] = id1[2*i];
			end else begin
				lv2[i] = lv1[2*i+1];
				id2[i] = id1[2*i+1];
			end
		end
		if (lv2[0] >= lv2[1]) begin
			best  = id2[0];
			found = lv2[0] != '0;
		end else begin
			best  = id2[1];
			found = 1'b1;
		end
	end

endmodule

// ===== rtl/core/loudest_channel_selector.sv =====
// ----------------------------------------------------------------------------
// Loudest channel selector
// A frame's result is offered from stage 2, after the stage 1 register and the registered store read.
// Throughput: one frame per cycle; the input stalls only when a result waits.
// Results replay the previous block's frames from the sample store.
// Reset clears the control state at once; the sample store is not cleared.
// ----------------------------------------------------------------------------
module loudest_channel_selector #(
	parameter int MAX_MICS    = 8,
	parameter int MAX_FRAMES  = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  lcs_pkg::cfg_reg_t                   cfg_index,
	input  logic [lcs_pkg::FPB_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample_0,
	input  logic signed [SAMPLE_BITS-1:0]       sample_1,
	input  logic signed [SAMPLE_BITS-1:0]       sample_2,
	input  logic signed [SAMPLE_BITS-1:0]       sample_3,
	input  logic signed [SAMPLE_BITS-1:0]       sample_4,
	input  logic signed [SAMPLE_BITS-1:0]       sample_5,
	input  logic signed [SAMPLE_BITS-1:0]       sample_6,
	input  logic signed [SAMPLE_BITS-1:0]       sample_7,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lcs_pkg::OUT_W-1:0]    sample_out,
	output lcs_pkg::ch_t                        mic_selected,
	output logic                                block_start,
	output logic                                mic_changed
);

	import lcs_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAMES);
	localparam int LEN_W = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W = ((LEN_W > FPB_W) ? LEN_W : FPB_W) + 1;

	// Configuration registers
	mics_t             active_mics_q;
	logic [FPB_W-1:0]  frames_per_block_q;

	// Block control
	logic [POS_W-1:0]  fpos_q;
	ch_t               sel_q;
	logic              chg_q;
	logic              hp_q;

	// Stage 1: registered input frame
	logic                                 v_s1;
	logic [MAX_MICS-1:0][SAMPLE_BITS-1:0] samp_s1;
	logic [POS_W-1:0]                     pos_s1;
	logic                                 last_s1;

	// Stage 2: store read data and result fields
	logic    v_s2;
	ch_t     sel_s2;
	logic    blk_s2;
	logic    chg_s2;
	logic    hp_s2;

	logic [CH_SLOTS-1:0][SAMPLE_BITS-1:0] all_in;
	logic [CH_SLOTS-1:0][SAMPLE_BITS-1:0] rd;
	logic [SAMPLE_BITS-1:0]               sel_rd;

	logic              in_fire;
	logic              s1_move;
	logic              s2_free;
	logic [CMP_W-1:0]  fpb_ext;
	logic [CMP_W-1:0]  len_eff;
	logic              last_in;
	mics_t             mics_eff;

	sum_t [MAX_MICS-1:0] final_sums;
	logic                final_valid;
	ch_t                 best;
	logic                found;
	ch_t                 sel_eff;
	logic                chg_eff;
	logic                hp_eff;
	acc_ctl_t            acc_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_mics_q      <= AM_W'(1);
			frames_per_block_q <= FPB_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ACTIVE_MICS:      active_mics_q      <= cfg_data[AM_W-1:0];
				CFG_FRAMES_PER_BLOCK: frames_per_block_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (active_mics_q == '0) begin
			mics_eff = AM_W'(1);
		end else if (active_mics_q > AM_W'(MAX_MICS)) begin
			mics_eff = AM_W'(MAX_MICS);
		end else begin
			mics_eff = active_mics_q;
		end
		fpb_ext = CMP_W'(frames_per_block_q);
		if (fpb_ext == '0) begin
			len_eff = CMP_W'(1);
		end else if (fpb_ext > CMP_W'(MAX_FRAMES)) begin
			len_eff = CMP_W'(MAX_FRAMES);
		end else begin
			len_eff = fpb_ext;
		end
		last_in = (CMP_W'(fpos_q) + CMP_W'(1)) >= len_eff;
	end

	assign all_in = {sample_7, sample_6, sample_5, sample_4,
		sample_3, sample_2, sample_1, sample_0};

	// Handshake: stage 2 frees when it holds no result or its result transfers.
	assign out_valid = v_s2 && hp_s2;
	assign s2_free   = !out_valid || !out_stall;
	assign s1_move   = v_s1 && s2_free;
	assign in_stall  = v_s1 && !s2_free;
	assign in_fire   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpos_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (in_fire) begin
				fpos_q <= last_in ? '0 : fpos_q + 1'b1;
			end
			v_s1 <= in_fire || (v_s1 && !s1_move);
			v_s2 <= s1_move || (v_s2 && !s2_free);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int c = 0; c < MAX_MICS; c++) begin
				samp_s1[c] <= all_in[c];
			end
			pos_s1  <= fpos_q;
			last_s1 <= last_in;
		end
	end

	assign acc_ctl.move = s1_move;
	assign acc_ctl.last = last_s1;

	lcs_energy #(
		.MAX_MICS    (MAX_MICS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_energy (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (acc_ctl),
		.mics        (mics_eff),
		.samples     (samp_s1),
		.final_sums  (final_sums),
		.final_valid (final_valid)
	);

	lcs_pick #(
		.MAX_MICS (MAX_MICS)
	) u_pick (
		.sums  (final_sums),
		.best  (best),
		.found (found)
	);

	// A new selection from the block totals is bypassed to the frame now leaving stage 1, before sel_q takes it.
	always_comb begin
		if (final_valid) begin
			sel_eff = found ? best : sel_q;
			chg_eff = sel_eff != sel_q;
			hp_eff  = 1'b1;
		end else begin
			sel_eff = sel_q;
			chg_eff = chg_q;
			hp_eff  = hp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
			chg_q <= 1'b0;
			hp_q  <= 1'b0;
		end else if (final_valid) begin
			sel_q <= sel_eff;
			chg_q <= chg_eff;
			hp_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			sel_s2 <= sel_eff;
			chg_s2 <= chg_eff;
			hp_s2  <= hp_eff;
			blk_s2 <= pos_s1 == '0;
		end
	end

	for (genvar c = 0; c < CH_SLOTS; c++) begin : g_store
		if (c < MAX_MICS) begin : g_ram
			lcs_ram #(
				.WIDTH (SAMPLE_BITS),
				.DEPTH (MAX_FRAMES)
			) u_ram (
				.clk   (clk),
				.we    (s1_move),
				.waddr (pos_s1),
				.wdata (samp_s1[c]),
				.re    (s1_move),
				.raddr (pos_s1),
				.rdata (rd[c])
			);
		end else begin : g_none
			assign rd[c] = '0;
		end
	end

	assign sel_rd = rd[sel_s2];

	if (SAMPLE_BITS >= OUT_W) begin : g_out_trunc
		assign sample_out = sel_rd[OUT_W-1:0];
	end else begin : g_out_ext
		assign sample_out = {{(OUT_W-SAMPLE_BITS){1'b0}}, sel_rd};
	end

	assign mic_selected = sel_s2;
	assign block_start  = blk_s2;
	assign mic_changed  = chg_s2;

endmodule

// ===== rtl/core/lcs_checker.sv =====
// ----------------------------------------------------------------------------
// Loudest channel selector checker
// Port-level checks on stalling, result holding and block consistency.
// ----------------------------------------------------------------------------
`include "loudest_channel_selector_assert.svh"

module lcs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_stall,
	input logic         out_valid,
	input logic         out_stall,
	input lcs_pkg::ch_t mic_selected,
	input logic         block_start,
	input logic         mic_changed
);

	import lcs_pkg::*;

	logic seen_q;
	ch_t  last_sel_q;
	logic last_chg_q;

	// Remember the last result transfer to compare frames within a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_sel_q <= '0;
			last_chg_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			seen_q     <= 1'b1;
			last_sel_q <= mic_selected;
			last_chg_q <= mic_changed;
		end
	end

	`LCS_ASSERT_NOW(a_stall_cause, in_valid && in_stall, out_valid && out_stall, "input stalled without a waiting result")
	`LCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mic_selected) && $stable(block_start), "stalled result changed")
	`LCS_ASSERT_NOW(a_first_start, out_valid && !seen_q, block_start, "first result is not a block start")
	`LCS_ASSERT_NOW(a_sel_in_block, out_valid && seen_q && !block_start, mic_selected == last_sel_q && mic_changed == last_chg_q, "selection changed inside a block")

endmodule

bind loudest_channel_selector lcs_checker u_lcs_checker (.*);
